// ===== hw/rtl/ppt_pkg.sv =====
// Shared types, codes and constants of the per-process page table.
package ppt_pkg;

  localparam int MAX_PROCS_DEF = 64;
  localparam int MAX_PAGES_DEF = 32;
  localparam int TIME_BITS     = 16;

  localparam int FRAME_W    = 8;
  localparam int TIME_W     = 16;
  localparam int COUNT_W    = 17;
  localparam int SIZE_W     = 6;
  localparam int FIELD_W    = 6;
  localparam int PAGE_OUT_W = 5;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 72;

  localparam logic [FRAME_W-1:0] FRAME_NONE = '1;
  localparam logic [COUNT_W-1:0] COUNT_NONE = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(65535);
  localparam logic [TIME_W-1:0]  TIME_MASK  = (TIME_BITS >= TIME_W) ? '1 :
                                              TIME_W'((33'd1 << TIME_BITS) - 33'd1);

  typedef enum logic [2:0] {
    OP_CREATE     = 3'd0,
    OP_LOOKUP     = 3'd1,
    OP_LOAD       = 3'd2,
    OP_INVALIDATE = 3'd3,
    OP_TOUCH      = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_LIST       = 3'd6,
    OP_SIZE       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_PROC     = 2'd1,
    ST_BAD_PAGE    = 2'd2,
    ST_NOT_PRESENT = 2'd3
  } status_t;

  // one stored page table entry
  typedef struct packed {
    logic                valid;
    logic [FRAME_W-1:0]  frame;
    logic                referenced;
    logic [TIME_W-1:0]   load_time;
    logic [TIME_W-1:0]   last_access;
    logic [COUNT_W-1:0]  access_count;
  } pte_t;

  // input beat, first field in the lowest bits
  typedef struct packed {
    logic [2:0]          pad;
    logic [TIME_W-1:0]   time_req;
    logic [FRAME_W-1:0]  frame;
    logic [FIELD_W-1:0]  page_count;
    logic [FIELD_W-1:0]  page;
    logic [FIELD_W-1:0]  process_id;
    op_t                 operation;
  } req_t;

  // result beat, first field in the lowest bits
  typedef struct packed {
    logic [SIZE_W-1:0]     size_out;
    logic [PAGE_OUT_W-1:0] page_out;
    logic [COUNT_W-1:0]    access_count_out;
    logic [TIME_W-1:0]     last_access_out;
    logic [TIME_W-1:0]     load_time_out;
    logic                  referenced_out;
    logic [FRAME_W-1:0]    frame_out;
    logic                  entry_valid;
    status_t               status;
  } res_t;

  function automatic res_t res_empty(input status_t st);
    res_t r;
    r = '0;
    r.status    = st;
    r.frame_out = FRAME_NONE;
    return r;
  endfunction

  function automatic pte_t pte_cleared();
    pte_t e;
    e = '0;
    e.frame        = FRAME_NONE;
    e.access_count = COUNT_NONE;
    return e;
  endfunction

endpackage

// ===== hw/rtl/ppt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ppt_ram #(
  parameter int WIDTH = ppt_pkg::SIZE_W,
  parameter int DEPTH = ppt_pkg::MAX_PROCS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/per_process_page_table.sv =====
// Top level of the per-process single-level page table.
//
// Usage: requests arrive as beats on the in_ channel (operation, process,
// page, page count, frame, time stamp); results leave as beats on the out_
// channel, each request closing with a beat that carries tlast.
// Process sizes sit in a small RAM with present bits in flops; page table
// entries sit in one RAM of MAX_PROCS * MAX_PAGES rows, with a registered read.
// Sequence: for lookup, load, invalidate, touch, remove and size the accept
// cycle issues both RAM reads, then S_EXEC modifies, writes back and loads
// the output register, waiting while that register still holds a beat.
// Create clears all MAX_PAGES entry-RAM rows of the new table, one write
// per row. List does one RAM read and one check per page.
// A new request is taken as soon as the last result of the previous one
// sits in the output register, even if that beat is still unclaimed.
// Stall: while out_tready is low the output register holds a valid beat,
// and a step that must load that register waits, including its write-back.
// Reset: present bits and control clear at once; there is no clearing pass,
// since create writes every entry of a table before any of it is read.
module per_process_page_table #(
  parameter int MAX_PROCS = ppt_pkg::MAX_PROCS_DEF,
  parameter int MAX_PAGES = ppt_pkg::MAX_PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata, lowest bit up: operation[2:0], process_id[8:3], page[14:9],
  // page_count[20:15], frame[28:21], time_req[44:29], zero pad[47:45]
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ppt_pkg::IN_W-1:0]   in_tdata,
  // out_tdata, lowest bit up: status[1:0], entry_valid[2], frame_out[10:3],
  // referenced_out[11], load_time_out[27:12], last_access_out[43:28],
  // access_count_out[60:44], page_out[65:61], size_out[71:66]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ppt_pkg::OUT_W-1:0]  out_tdata,
  output logic                       out_tlast
);

  localparam int ENTRIES = MAX_PROCS * MAX_PAGES;
  localparam int PID_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int PG_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);
  localparam int SIZE_W  = ppt_pkg::SIZE_W;
  localparam int PTE_W   = $bits(ppt_pkg::pte_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_CDONE,
    S_LRD,
    S_LCHK,
    S_LEND
  } state_t;

  state_t state_r, state_nxt;

  ppt_pkg::req_t req_r, req_nxt;
  logic [PID_W-1:0]   pid_r, pid_nxt;
  logic               inrange_r, inrange_nxt;
  logic               present_r, present_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [SIZE_W-1:0]  sz_r, sz_nxt;
  logic [PG_W-1:0]    pend_r, pend_nxt;
  logic               have_pend_r, have_pend_nxt;
  logic [MAX_PROCS-1:0] vld_r, vld_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_last_r, out_last_nxt;
  ppt_pkg::res_t      out_data_r, out_data_nxt;

  // RAM ports
  logic               prc_we, prc_re;
  logic [PID_W-1:0]   prc_waddr;
  logic [SIZE_W-1:0]  prc_wdata, prc_rdata;
  logic               pte_we, pte_re;
  logic [ADDR_W-1:0]  pte_waddr, pte_raddr;
  ppt_pkg::pte_t      pte_wdata, pte_rdata;
  logic [PTE_W-1:0]   pte_rdata_raw;

  // accept-side decode
  ppt_pkg::req_t      req_in;
  logic [31:0]        pid_ext, page_ext;
  logic [PID_W-1:0]   pid_idx;
  logic [PG_W-1:0]    page_idx;
  logic [ADDR_W-1:0]  base_in;
  logic               in_acc;
  logic               out_free;

  assign req_in   = ppt_pkg::req_t'(in_tdata);
  assign pid_ext  = 32'(req_in.process_id);
  assign page_ext = 32'(req_in.page);
  assign pid_idx  = pid_ext[PID_W-1:0];
  assign page_idx = page_ext[PG_W-1:0];
  assign base_in  = ADDR_W'(int'(pid_idx) * MAX_PAGES);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign pte_rdata  = ppt_pkg::pte_t'(pte_rdata_raw);

  // sequencer working values
  logic [SIZE_W-1:0]  size_cur;
  logic [SIZE_W-1:0]  size_sat;
  logic               page_ok;
  ppt_pkg::pte_t      ent;
  ppt_pkg::res_t      res;
  logic               ent_write;
  logic [31:0]        pend_ext, i_ext;
  logic [ppt_pkg::TIME_W-1:0] now;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    pid_nxt       = pid_r;
    inrange_nxt   = inrange_r;
    present_nxt   = present_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    i_nxt         = i_r;
    sz_nxt        = sz_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    vld_nxt       = vld_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    prc_we    = 1'b0;
    prc_re    = 1'b0;
    prc_waddr = pid_r;
    prc_wdata = sz_r;
    pte_we    = 1'b0;
    pte_re    = 1'b0;
    pte_waddr = addr_r;
    pte_wdata = pte_rdata;
    pte_raddr = base_in + ADDR_W'(page_idx);

    size_cur = present_r ? prc_rdata : '0;
    size_sat = (32'(req_r.page_count) > MAX_PAGES) ? SIZE_W'(MAX_PAGES) : req_r.page_count;
    page_ok  = (32'(req_r.page) < 32'(size_cur)) && (32'(req_r.page) < MAX_PAGES);
    now      = req_r.time_req & ppt_pkg::TIME_MASK;
    pend_ext = 32'(pend_r);
    i_ext    = 32'(i_r);
    ent      = pte_rdata;
    ent_write = 1'b0;
    res      = ppt_pkg::res_empty(ppt_pkg::ST_OK);

    unique case (state_r)
      S_IDLE: begin
        // issue both reads on accept
        if (in_acc) begin
          req_nxt     = req_in;
          pid_nxt     = pid_idx;
          inrange_nxt = pid_ext < MAX_PROCS;
          present_nxt = (pid_ext < MAX_PROCS) && vld_r[pid_idx];
          base_nxt    = base_in;
          addr_nxt    = base_in + ADDR_W'(page_idx);
          prc_re      = 1'b1;
          pte_re      = 1'b1;
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        // build the entry after the operation
        unique case (req_r.operation)
          ppt_pkg::OP_LOAD: begin
            ent.valid        = 1'b1;
            ent.frame        = req_r.frame;
            ent.referenced   = 1'b1;
            ent.load_time    = now;
            ent.last_access  = now;
            ent.access_count = ppt_pkg::COUNT_ONE;
            ent_write        = 1'b1;
          end
          ppt_pkg::OP_INVALIDATE: begin
            ent.valid      = 1'b0;
            ent.frame      = ppt_pkg::FRAME_NONE;
            ent.referenced = 1'b0;
            ent_write      = 1'b1;
          end
          ppt_pkg::OP_TOUCH: begin
            if (pte_rdata.valid) begin
              if (req_r.frame != ppt_pkg::FRAME_NONE) begin
                ent.frame = req_r.frame;
              end
              ent.referenced  = 1'b1;
              ent.last_access = now;
              if (pte_rdata.access_count == ppt_pkg::COUNT_NONE) begin
                ent.access_count = ppt_pkg::COUNT_ONE;
              end else if (pte_rdata.access_count < ppt_pkg::COUNT_MAX) begin
                ent.access_count = pte_rdata.access_count + ppt_pkg::COUNT_ONE;
              end else begin
                ent.access_count = ppt_pkg::COUNT_MAX;
              end
              ent_write = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (req_r.operation == ppt_pkg::OP_CREATE && inrange_r) begin
          // record the size now, then sweep the table
          prc_we        = 1'b1;
          prc_wdata     = size_sat;
          vld_nxt[pid_r] = 1'b1;
          sz_nxt        = size_sat;
          i_nxt         = '0;
          state_nxt     = S_CLEAR;
        end else if (req_r.operation == ppt_pkg::OP_LIST && present_r) begin
          sz_nxt        = size_cur;
          i_nxt         = '0;
          have_pend_nxt = 1'b0;
          state_nxt     = (size_cur == '0) ? S_LEND : S_LRD;
        end else if (out_free) begin
          // single-beat answers: commit and present together
          if (!present_r) begin
            res = ppt_pkg::res_empty(ppt_pkg::ST_NO_PROC);
          end else begin
            unique case (req_r.operation)
              ppt_pkg::OP_REMOVE: begin
                vld_nxt[pid_r] = 1'b0;
              end
              ppt_pkg::OP_SIZE: begin
                res.size_out = size_cur;
              end
              default: begin
                if (!page_ok) begin
                  res = ppt_pkg::res_empty(ppt_pkg::ST_BAD_PAGE);
                end else begin
                  pte_we    = ent_write;
                  pte_waddr = addr_r;
                  pte_wdata = ent;
                  res.entry_valid      = ent.valid;
                  res.frame_out        = ent.frame;
                  res.referenced_out   = ent.referenced;
                  res.load_time_out    = ent.load_time;
                  res.last_access_out  = ent.last_access;
                  res.access_count_out = ent.access_count;
                  if ((req_r.operation == ppt_pkg::OP_LOOKUP ||
                       req_r.operation == ppt_pkg::OP_TOUCH) && !pte_rdata.valid) begin
                    res.status = ppt_pkg::ST_NOT_PRESENT;
                  end
                end
              end
            endcase
          end
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_data_nxt  = res;
          state_nxt     = S_IDLE;
        end
      end

      S_CLEAR: begin
        pte_we    = 1'b1;
        pte_waddr = base_r + ADDR_W'(i_r);
        pte_wdata = ppt_pkg::pte_cleared();
        if (i_r == CNT_W'(MAX_PAGES - 1)) begin
          state_nxt = S_CDONE;
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end

      S_CDONE: begin
        if (out_free) begin
          res.size_out  = sz_r;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_data_nxt  = res;
          state_nxt     = S_IDLE;
        end
      end

      S_LRD: begin
        pte_re    = 1'b1;
        pte_raddr = base_r + ADDR_W'(i_r);
        state_nxt = S_LCHK;
      end

      S_LCHK: begin
        // keep one found page back so the final one can carry tlast
        if (!(pte_rdata.valid && have_pend_r && !out_free)) begin
          if (pte_rdata.valid) begin
            if (have_pend_r) begin
              res.page_out  = pend_ext[ppt_pkg::PAGE_OUT_W-1:0];
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b0;
              out_data_nxt  = res;
            end
            pend_nxt      = i_r[PG_W-1:0];
            have_pend_nxt = 1'b1;
          end
          if (i_ext + 32'd1 >= 32'(sz_r)) begin
            state_nxt = S_LEND;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_LRD;
          end
        end
      end

      S_LEND: begin
        if (out_free) begin
          if (have_pend_r) begin
            res.page_out = pend_ext[ppt_pkg::PAGE_OUT_W-1:0];
          end else begin
            res.status = ppt_pkg::ST_NOT_PRESENT;
          end
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_data_nxt  = res;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      have_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      have_pend_r <= have_pend_nxt;
    end
    // payload, no reset needed
    req_r      <= req_nxt;
    pid_r      <= pid_nxt;
    inrange_r  <= inrange_nxt;
    present_r  <= present_nxt;
    base_r     <= base_nxt;
    addr_r     <= addr_nxt;
    i_r        <= i_nxt;
    sz_r       <= sz_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // process sizes, one row per process
  ppt_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_PROCS)
  ) u_prc_ram (
    .clk   (clk),
    .we    (prc_we),
    .waddr (prc_waddr),
    .wdata (prc_wdata),
    .re    (prc_re),
    .raddr (pid_idx),
    .rdata (prc_rdata)
  );

  // page table entries, MAX_PAGES rows per process
  ppt_ram #(
    .WIDTH (PTE_W),
    .DEPTH (ENTRIES)
  ) u_pte_ram (
    .clk   (clk),
    .we    (pte_we),
    .waddr (pte_waddr),
    .wdata (pte_wdata),
    .re    (pte_re),
    .raddr (pte_raddr),
    .rdata (pte_rdata_raw)
  );

endmodule
